// ===== src/psct_pkg.sv =====
package psct_pkg;

  localparam int COORD_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_SEG  = 2'd0,
    KIND_BOX  = 2'd1,
    KIND_CIRC = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PAIR_NONE,
    PAIR_SS,
    PAIR_SB,
    PAIR_SC,
    PAIR_BB,
    PAIR_BC,
    PAIR_CC
  } pair_t;

  // side_cross: top, bottom, left, right box edge straddled by the segment
  typedef struct packed {
    logic [3:0] side_cross;
    logic [1:0] in_box;
    logic       bb;
  } geo_flags_t;

endpackage

// ===== src/pairwise_shape_collision_test.sv =====
// Pairwise 2D shape collision test.
// Input channel: in_valid / in_stall carry one request, a pair of shapes
// (kind code plus four signed fixed-point words each). A request is taken
// at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result bit, hit, per
// request, in request order.
// Throughput: one request per cycle, sustained while the receiver does not stall.
// The five register stages are: operand build, first products, sums,
// second products, final select. All stages advance together.
// When the receiver holds out_stall with a result waiting, the whole
// pipeline holds and in_stall rises in the same cycle; nothing is lost or
// repeated. A kind code of three on either side gives hit = 0.
// Reset (rst, synchronous, active high) empties the pipeline; no result is
// pending afterwards.
module pairwise_shape_collision_test #(
  parameter int COORD_BITS = psct_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind_a,
  input  logic signed [COORD_BITS-1:0] shape_a_p0,
  input  logic signed [COORD_BITS-1:0] shape_a_p1,
  input  logic signed [COORD_BITS-1:0] shape_a_p2,
  input  logic signed [COORD_BITS-1:0] shape_a_p3,
  input  logic [1:0]                   kind_b,
  input  logic signed [COORD_BITS-1:0] shape_b_p0,
  input  logic signed [COORD_BITS-1:0] shape_b_p1,
  input  logic signed [COORD_BITS-1:0] shape_b_p2,
  input  logic signed [COORD_BITS-1:0] shape_b_p3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         hit
);

  localparam int DW  = COORD_BITS + 3;
  localparam int MW  = 2 * DW;
  localparam int SW  = MW + 1;
  localparam int QW  = 2 * SW;
  localparam int NW  = SW + 3;
  localparam int LW  = (SW + 1) / 2;
  localparam int HW  = SW - LW;
  localparam int LW2 = 2 * LW;
  localparam int HW2 = 2 * HW;
  localparam int RHW = MW - LW + HW;

  function automatic logic [COORD_BITS-1:0] magw(input logic signed [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? COORD_BITS'(-v) : COORD_BITS'(v);
  endfunction

  function automatic logic signed [DW-1:0] dbl(input logic signed [COORD_BITS-1:0] v);
    return DW'($signed({v, 1'b0}));
  endfunction

  function automatic logic strad(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
                                 input logic signed [DW-1:0] r);
    return (a > r && b < r) || (a < r && b > r);
  endfunction

  function automatic logic opp(input logic signed [SW-1:0] a, input logic signed [SW-1:0] b);
    return (a > 0 && b < 0) || (a < 0 && b > 0);
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage A: normalise order, build points and boxes, pick multiplier operands
  logic                         swap;
  logic [1:0]                   ka, kb;
  logic signed [COORD_BITS-1:0] sa [4];
  logic signed [COORD_BITS-1:0] sb [4];
  logic signed [DW-1:0] p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
  logic signed [DW-1:0] ahw, ahh, bhw, bhh;
  logic signed [DW-1:0] alx, arx, aby, aty, blx, brx, bby, bty;
  logic signed [DW-1:0] ra, rb, lx, ly, mx, my, tx, ty, qx, qy;
  logic signed [DW-1:0] crx [4];
  logic signed [DW-1:0] cry [4];

  psct_pkg::pair_t      pair_next, pair1, pair2, pair3;
  psct_pkg::geo_flags_t flags_next, flags1, flags2, flags3;
  logic signed [DW-1:0] opx_next [8];
  logic signed [DW-1:0] opy_next [8];
  logic signed [DW-1:0] opr_next;
  logic signed [DW-1:0] opx [8];
  logic signed [DW-1:0] opy [8];
  logic signed [DW-1:0] opr;

  always_comb begin
    swap  = kind_a > kind_b;
    ka    = swap ? kind_b : kind_a;
    kb    = swap ? kind_a : kind_b;
    sa[0] = swap ? shape_b_p0 : shape_a_p0;
    sa[1] = swap ? shape_b_p1 : shape_a_p1;
    sa[2] = swap ? shape_b_p2 : shape_a_p2;
    sa[3] = swap ? shape_b_p3 : shape_a_p3;
    sb[0] = swap ? shape_a_p0 : shape_b_p0;
    sb[1] = swap ? shape_a_p1 : shape_b_p1;
    sb[2] = swap ? shape_a_p2 : shape_b_p2;
    sb[3] = swap ? shape_a_p3 : shape_b_p3;

    p1x = dbl(sa[0]);
    p1y = dbl(sa[1]);
    p2x = dbl(sa[2]);
    p2y = dbl(sa[3]);
    q1x = dbl(sb[0]);
    q1y = dbl(sb[1]);
    q2x = dbl(sb[2]);
    q2y = dbl(sb[3]);
    ahw = DW'(magw(sa[2]));
    ahh = DW'(magw(sa[3]));
    bhw = DW'(magw(sb[2]));
    bhh = DW'(magw(sb[3]));
    alx = p1x - ahw;
    arx = p1x + ahw;
    aby = p1y - ahh;
    aty = p1y + ahh;
    blx = q1x - bhw;
    brx = q1x + bhw;
    bby = q1y - bhh;
    bty = q1y + bhh;
    ra  = ahw <<< 1;
    rb  = bhw <<< 1;
    lx  = p2x - p1x;
    ly  = p2y - p1y;
    mx  = q2x - q1x;
    my  = q2y - q1y;
    tx  = q1x - p1x;
    ty  = q1y - p1y;
    qx  = (q1x < alx) ? alx : ((q1x > arx) ? arx : q1x);
    qy  = (q1y < aby) ? aby : ((q1y > aty) ? aty : q1y);
    crx[0] = blx; cry[0] = bby;
    crx[1] = blx; cry[1] = bty;
    crx[2] = brx; cry[2] = bby;
    crx[3] = brx; cry[3] = bty;

    if (ka > 2'(psct_pkg::KIND_CIRC) || kb > 2'(psct_pkg::KIND_CIRC)) begin
      pair_next = psct_pkg::PAIR_NONE;
    end else if (ka == 2'(psct_pkg::KIND_SEG)) begin
      if (kb == 2'(psct_pkg::KIND_SEG)) pair_next = psct_pkg::PAIR_SS;
      else if (kb == 2'(psct_pkg::KIND_BOX)) pair_next = psct_pkg::PAIR_SB;
      else pair_next = psct_pkg::PAIR_SC;
    end else if (ka == 2'(psct_pkg::KIND_BOX)) begin
      if (kb == 2'(psct_pkg::KIND_BOX)) pair_next = psct_pkg::PAIR_BB;
      else pair_next = psct_pkg::PAIR_BC;
    end else begin
      pair_next = psct_pkg::PAIR_CC;
    end

    flags_next.side_cross[0] = (brx > blx) && strad(p1y, p2y, bty);
    flags_next.side_cross[1] = (brx > blx) && strad(p1y, p2y, bby);
    flags_next.side_cross[2] = (bty > bby) && strad(p1x, p2x, blx);
    flags_next.side_cross[3] = (bty > bby) && strad(p1x, p2x, brx);
    flags_next.in_box[0] = p1x >= blx && p1x <= brx && p1y >= bby && p1y <= bty;
    flags_next.in_box[1] = p2x >= blx && p2x <= brx && p2y >= bby && p2y <= bty;
    flags_next.bb = !(arx < blx || aty < bby || brx < alx || bty < aby);

    for (int i = 0; i < 8; i++) begin
      opx_next[i] = '0;
      opy_next[i] = '0;
    end
    opr_next = '0;
    case (pair_next)
      psct_pkg::PAIR_SS: begin
        opx_next[0] = lx; opy_next[0] = q1y - p1y;
        opx_next[1] = ly; opy_next[1] = q1x - p1x;
        opx_next[2] = lx; opy_next[2] = q2y - p1y;
        opx_next[3] = ly; opy_next[3] = q2x - p1x;
        opx_next[4] = mx; opy_next[4] = p1y - q1y;
        opx_next[5] = my; opy_next[5] = p1x - q1x;
        opx_next[6] = mx; opy_next[6] = p2y - q1y;
        opx_next[7] = my; opy_next[7] = p2x - q1x;
      end
      psct_pkg::PAIR_SB: begin
        for (int k = 0; k < 4; k++) begin
          opx_next[2*k]   = lx; opy_next[2*k]   = cry[k] - p1y;
          opx_next[2*k+1] = ly; opy_next[2*k+1] = crx[k] - p1x;
        end
      end
      psct_pkg::PAIR_SC: begin
        opx_next[0] = tx; opy_next[0] = lx;
        opx_next[1] = ty; opy_next[1] = ly;
        opx_next[2] = lx; opy_next[2] = lx;
        opx_next[3] = ly; opy_next[3] = ly;
        opx_next[4] = lx; opy_next[4] = ty;
        opx_next[5] = ly; opy_next[5] = tx;
        opx_next[6] = tx; opy_next[6] = tx;
        opx_next[7] = ty; opy_next[7] = ty;
        opr_next    = rb;
      end
      psct_pkg::PAIR_BC: begin
        opx_next[0] = qx - q1x; opy_next[0] = qx - q1x;
        opx_next[1] = qy - q1y; opy_next[1] = qy - q1y;
        opr_next    = rb;
      end
      psct_pkg::PAIR_CC: begin
        opx_next[0] = tx; opy_next[0] = tx;
        opx_next[1] = ty; opy_next[1] = ty;
        opr_next    = ra + rb;
      end
      default: begin
      end
    endcase
  end

  // stage B: first products
  logic signed [MW-1:0] prod [8];
  logic signed [MW-1:0] prodr;

  // stage C: sums
  logic signed [SW-1:0] crs [4];
  logic signed [SW-1:0] sum0, sum1, sum3;
  logic signed [MW-1:0] r2;

  // stage D: second products and decisions
  logic signed [NW-1:0] far_d2;
  logic                 early_next, use_cr_next, early, use_cr;
  logic [SW-1:0]        crm;
  logic [LW-1:0]        crl, r2l, s1l;
  logic [HW-1:0]        crh, s1h;
  logic [MW-LW-1:0]     r2h;
  logic [LW2-1:0]       cp_ll, rp_ll;
  logic [SW-1:0]        cp_hl, rp_lh;
  logic [HW2-1:0]       cp_hh;
  logic [MW-1:0]        rp_hl;
  logic [RHW-1:0]       rp_hh;

  // stage E: combine partial products
  logic [QW-1:0]        crsq, rll;

  always_comb begin
    far_d2      = NW'(sum3) - NW'(sum0) - NW'(sum0) + NW'(sum1);
    crm         = crs[2][SW-1] ? $unsigned(-crs[2]) : $unsigned(crs[2]);
    crl         = crm[LW-1:0];
    crh         = crm[SW-1:LW];
    r2l         = r2[LW-1:0];
    r2h         = r2[MW-1:LW];
    s1l         = sum1[LW-1:0];
    s1h         = sum1[SW-1:LW];
    early_next  = 1'b0;
    use_cr_next = 1'b0;
    case (pair3)
      psct_pkg::PAIR_SS: early_next = opp(crs[0], crs[1]) && opp(crs[2], crs[3]);
      psct_pkg::PAIR_SB: begin
        early_next = (flags3.side_cross[0] && opp(crs[1], crs[3])) ||
                     (flags3.side_cross[1] && opp(crs[0], crs[2])) ||
                     (flags3.side_cross[2] && opp(crs[0], crs[1])) ||
                     (flags3.side_cross[3] && opp(crs[2], crs[3])) ||
                     (|flags3.in_box);
      end
      psct_pkg::PAIR_SC: begin
        if (sum0 <= 0) early_next = SW'(sum3) <= SW'(r2);
        else if (sum0 >= sum1) early_next = far_d2 <= NW'(r2);
        else use_cr_next = 1'b1;
      end
      psct_pkg::PAIR_BB: early_next = flags3.bb;
      psct_pkg::PAIR_BC: early_next = sum0 <= SW'(r2);
      psct_pkg::PAIR_CC: early_next = sum0 <= SW'(r2);
      default: early_next = 1'b0;
    endcase
  end

  always_comb begin
    crsq = (QW'(cp_hh) << LW2) + (QW'(cp_hl) << (LW + 1)) + QW'(cp_ll);
    rll  = (QW'(rp_hh) << LW2) + (QW'(rp_hl) << LW) + (QW'(rp_lh) << LW) + QW'(rp_ll);
  end

  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair1  <= pair_next;
      flags1 <= flags_next;
      for (int i = 0; i < 8; i++) begin
        opx[i] <= opx_next[i];
        opy[i] <= opy_next[i];
      end
      opr <= opr_next;

      pair2  <= pair1;
      flags2 <= flags1;
      for (int i = 0; i < 8; i++) prod[i] <= MW'(opx[i]) * MW'(opy[i]);
      prodr <= MW'(opr) * MW'(opr);

      pair3  <= pair2;
      flags3 <= flags2;
      for (int k = 0; k < 4; k++) crs[k] <= SW'(prod[2*k]) - SW'(prod[2*k+1]);
      sum0 <= SW'(prod[0]) + SW'(prod[1]);
      sum1 <= SW'(prod[2]) + SW'(prod[3]);
      sum3 <= SW'(prod[6]) + SW'(prod[7]);
      r2   <= prodr;

      early  <= early_next;
      use_cr <= use_cr_next;
      cp_ll  <= LW2'(crl) * LW2'(crl);
      cp_hl  <= SW'(crh) * SW'(crl);
      cp_hh  <= HW2'(crh) * HW2'(crh);
      rp_ll  <= LW2'(r2l) * LW2'(s1l);
      rp_hl  <= MW'(r2h) * MW'(s1l);
      rp_lh  <= SW'(r2l) * SW'(s1h);
      rp_hh  <= RHW'(r2h) * RHW'(s1h);

      hit <= use_cr ? (crsq <= rll) : early;
    end
  end

`ifndef SYNTHESIS
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v4) |=> out_valid)
    else $error("request dropped at last stage");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !v4) |=> !out_valid)
    else $error("result repeated after delivery");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    (!en) |=> ($stable(v1) && $stable(v2) && $stable(v3) && $stable(v4)))
    else $error("pipeline moved while held");
`endif

endmodule
